>>> hw/rtl/imconv_pkg.sv
// ----------------------------------------------------------------------------
// imconv_pkg
// Shared types and constants of the 3x3 replicate-edge image convolution.
// ----------------------------------------------------------------------------
package imconv_pkg;

  localparam int KERNEL_SIZE   = 3;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int QUEUE_DEPTH   = 4;
  localparam int PIXEL_W       = 8;
  localparam int VALUE_W       = 20;
  localparam int HEIGHT_W      = 13;
  localparam int CFG_WIDTH_W   = 11;
  localparam int KROW_W        = 24;
  localparam int CFG_ADDR_W    = 5;
  localparam int CFG_DATA_W    = 32;

  // Register indexes on the configuration port (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4
  } reg_idx_t;

  // Per-item control decided by the front and carried out by the back.
  typedef struct packed {
    logic top_clamp;  // window top row replicates the center row
    logic bot_clamp;  // window bottom row replicates the center row
    logic col_zero;   // item sits in column 0 of its stream row
    logic col_one;    // item sits in column 1 of its stream row
    logic w_one;      // image is one pixel wide
    logic has_out;    // item produces an output pixel
    logic last;       // that output ends the frame
  } item_flags_t;

  // One window column, index 0 is the top row.
  typedef logic [KERNEL_SIZE-1:0][PIXEL_W-1:0] column_t;

endpackage

>>> hw/rtl/image_convolution_replicate_edges.sv
// ----------------------------------------------------------------------------
// image_convolution_replicate_edges
// 3x3 convolution of a raster pixel stream with replicated image edges.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one item per cycle: tdata holds the pixel and
//   tuser marks a drain tick. After the last pixel of a frame, width + 1
//   drain ticks flush the remaining outputs. The master stream gives one
//   window sum per pixel in raster order, with tlast on the final one.
//   An output belongs to the item width + 1 stream positions after its
//   pixel. Throughput is one item per cycle while the receiver keeps up,
//   set by the single line buffer port pair (one read and one write a
//   cycle) and the nine-multiplier array. A four-item queue parts the
//   classifier from the datapath, so input is taken while a result waits.
//   When the receiver stalls, the datapath holds and the queue fills;
//   tready drops once it is full. Reset restores the register defaults
//   and the frame position; the line buffer needs no clearing. Writing
//   width or height restarts the frame.
// ----------------------------------------------------------------------------
module image_convolution_replicate_edges
  import imconv_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] pixel
  input  logic                  s_tuser,   // [0] req_type
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [19:0] conv_value, [23:20] zero
  output logic                  m_tlast,   // frame_last
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int COLW   = $clog2(MAX_WIDTH);
  localparam int WW     = COLW + 1;
  localparam int ITEM_W = $bits(item_flags_t) + PIXEL_W + COLW;

  logic [CFG_WIDTH_W-1:0] image_width;
  logic [HEIGHT_W-1:0]    image_height;
  logic [KROW_W-1:0]      kernel_row_top;
  logic [KROW_W-1:0]      kernel_row_mid;
  logic [KROW_W-1:0]      kernel_row_bot;

  logic                   cfg_wr;
  reg_idx_t               cfg_idx;
  logic                   size_clear;
  logic [HEIGHT_W-1:0]    w_ext;
  logic [WW-1:0]          eff_w;
  logic [HEIGHT_W-1:0]    eff_h;

  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  item_flags_t            f_flags;
  logic [PIXEL_W-1:0]     f_pixel;
  logic [COLW-1:0]        f_col;
  logic [ITEM_W-1:0]      q_in;
  logic [ITEM_W-1:0]      q_out;
  item_flags_t            b_flags;
  logic [PIXEL_W-1:0]     b_pixel;
  logic [COLW-1:0]        b_col;
  logic [VALUE_W-1:0]     out_value;

  // Configuration registers.
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign size_clear = cfg_wr && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= CFG_WIDTH_W'(640);
      image_height   <= HEIGHT_W'(480);
      kernel_row_top <= '0;
      kernel_row_mid <= '0;
      kernel_row_bot <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  image_width    <= pwdata[CFG_WIDTH_W-1:0];
        REG_HEIGHT: image_height   <= pwdata[HEIGHT_W-1:0];
        REG_KTOP:   kernel_row_top <= pwdata[KROW_W-1:0];
        REG_KMID:   kernel_row_mid <= pwdata[KROW_W-1:0];
        REG_KBOT:   kernel_row_bot <= pwdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = CFG_DATA_W'(image_width);
      REG_HEIGHT: prdata = CFG_DATA_W'(image_height);
      REG_KTOP:   prdata = CFG_DATA_W'(kernel_row_top);
      REG_KMID:   prdata = CFG_DATA_W'(kernel_row_mid);
      REG_KBOT:   prdata = CFG_DATA_W'(kernel_row_bot);
      default:    prdata = '0;
    endcase
  end

  // Effective frame size: zero reads as one, oversize reads as the maximum.
  always_comb begin
    w_ext = HEIGHT_W'(image_width);
    if (w_ext == '0)                          eff_w = WW'(1);
    else if (w_ext > HEIGHT_W'(MAX_WIDTH))    eff_w = WW'(MAX_WIDTH);
    else                                      eff_w = WW'(w_ext);
    if (image_height == '0)                   eff_h = HEIGHT_W'(1);
    else if (image_height > HEIGHT_W'(MAX_HEIGHT)) eff_h = HEIGHT_W'(MAX_HEIGHT);
    else                                      eff_h = image_height;
  end

  imconv_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .clear    (size_clear),
    .img_w    (eff_w),
    .img_h    (eff_h),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .req_type (s_tuser),
    .pixel    (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_flags  (f_flags),
    .q_pixel  (f_pixel),
    .q_col    (f_col)
  );

  assign q_in = {f_flags, f_pixel, f_col};

  imconv_queue #(.DATA_W(ITEM_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign {b_flags, b_pixel, b_col} = q_out;

  imconv_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_flags   (b_flags),
    .q_pixel   (b_pixel),
    .q_col     (b_col),
    .k_top     (kernel_row_top),
    .k_mid     (kernel_row_mid),
    .k_bot     (kernel_row_bot),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (out_value),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0000, out_value};

endmodule

>>> hw/rtl/imconv_queue.sv
// ----------------------------------------------------------------------------
// imconv_queue
// Small FIFO that decouples the item classifier from the convolution datapath.
// ----------------------------------------------------------------------------
module imconv_queue
  import imconv_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      if (pop)  rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (!push && pop) count <= count - CNT_W'(1);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_data;
  end

endmodule

>>> hw/rtl/imconv_front.sv
// ----------------------------------------------------------------------------
// imconv_front
// Accepts input items, tracks stream and output positions, and classifies
// each item for the datapath.
// ----------------------------------------------------------------------------
module imconv_front
  import imconv_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic [$clog2(MAX_WIDTH):0]   img_w,
  input  logic [HEIGHT_W-1:0]          img_h,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [PIXEL_W-1:0]           pixel,
  input  logic                         q_full,
  output logic                         q_push,
  output item_flags_t                  q_flags,
  output logic [PIXEL_W-1:0]           q_pixel,
  output logic [$clog2(MAX_WIDTH)-1:0] q_col
);

  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int WW   = COLW + 1;

  logic [COLW-1:0]     in_col;
  logic [HEIGHT_W-1:0] in_row;
  logic [COLW-1:0]     out_col;
  logic [HEIGHT_W-1:0] out_row;

  logic [COLW-1:0]     in_col_next;
  logic [HEIGHT_W-1:0] in_row_next;
  logic [COLW-1:0]     out_col_next;
  logic [HEIGHT_W-1:0] out_row_next;

  logic pixels_done;
  logic in_wrap;
  logic out_wrap;
  logic has_out;
  logic last;

  assign in_ready    = !q_full;
  assign pixels_done = (in_row >= img_h);

  // Early drain ticks are dropped without touching any state.
  assign q_push = in_valid && in_ready && !(req_type && !pixels_done);

  // An output is due once the stream is one row and one pixel ahead.
  assign has_out = (in_row >= HEIGHT_W'(2)) || ((in_row == HEIGHT_W'(1)) && (in_col != '0));
  assign last    = has_out && (out_row == img_h - HEIGHT_W'(1)) &&
                   ({1'b0, out_col} == img_w - WW'(1));

  assign in_wrap  = ({1'b0, in_col} + WW'(1)) >= img_w;
  assign out_wrap = ({1'b0, out_col} + WW'(1)) >= img_w;

  // Position updates.
  always_comb begin
    in_col_next  = in_wrap ? '0 : in_col + COLW'(1);
    in_row_next  = in_wrap ? in_row + HEIGHT_W'(1) : in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (has_out) begin
      out_col_next = out_wrap ? '0 : out_col + COLW'(1);
      out_row_next = out_wrap ? out_row + HEIGHT_W'(1) : out_row;
    end
    if (last) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (q_push) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // Classification handed to the datapath.
  always_comb begin
    q_flags.top_clamp = (in_row == HEIGHT_W'(1));
    q_flags.bot_clamp = (in_row == img_h);
    q_flags.col_zero  = (in_col == '0);
    q_flags.col_one   = (in_col == COLW'(1));
    q_flags.w_one     = (img_w == WW'(1));
    q_flags.has_out   = has_out;
    q_flags.last      = last;
  end

  assign q_pixel = pixel;
  assign q_col   = in_col;

endmodule

>>> hw/rtl/imconv_back.sv
// ----------------------------------------------------------------------------
// imconv_back
// Line buffer, 3x3 window, multiplier array and adder tree with the output
// register.
// ----------------------------------------------------------------------------
module imconv_back
  import imconv_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  item_flags_t                  q_flags,
  input  logic [PIXEL_W-1:0]           q_pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  input  logic [KROW_W-1:0]            k_top,
  input  logic [KROW_W-1:0]            k_mid,
  input  logic [KROW_W-1:0]            k_bot,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [VALUE_W-1:0]           out_value,
  output logic                         out_last
);

  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int PROD_W = 2 * PIXEL_W;
  localparam int ROWS_W = PROD_W + 2;
  localparam int LB_W   = 2 * PIXEL_W;

  // Line buffer: low byte holds the row above, high byte the row before that.
  logic [LB_W-1:0] lbuf [MAX_WIDTH];

  logic en;

  logic                s1_valid;
  item_flags_t         s1_flags;
  logic [PIXEL_W-1:0]  s1_pixel;
  logic [COLW-1:0]     s1_col;

  logic                s2_valid;
  item_flags_t         s2_flags;
  logic [PIXEL_W-1:0]  s2_pixel;
  logic [COLW-1:0]     s2_col;
  logic [LB_W-1:0]     rd_data;
  logic                fwd;
  logic [LB_W-1:0]     fwd_data;

  logic [LB_W-1:0]     lb_word;
  logic [LB_W-1:0]     wr_data;
  column_t             new_col;

  column_t             col_a;
  column_t             col_b;
  column_t             col_c;

  logic                s3_valid;
  item_flags_t         s3_flags;
  column_t             win_l;
  column_t             win_c;
  column_t             win_r;
  logic [KERNEL_SIZE-1:0][KROW_W-1:0] krow;
  logic [PROD_W-1:0]   prod_next [KERNEL_SIZE][KERNEL_SIZE];

  logic                s4_valid;
  logic                s4_last;
  logic [PROD_W-1:0]   prod [KERNEL_SIZE][KERNEL_SIZE];
  logic [ROWS_W-1:0]   rsum_next [KERNEL_SIZE];

  logic                s5_valid;
  logic                s5_last;
  logic [ROWS_W-1:0]   rsum [KERNEL_SIZE];
  logic [VALUE_W-1:0]  total;

  // The whole datapath advances unless a finished result is stuck.
  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  // Valid chain; only items that produce a result go past the window.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= q_pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid && s2_flags.has_out;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
  end

  // Stage one and two payload, line buffer read with write forwarding.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_flags <= q_flags;
      s1_pixel <= q_pixel;
      s1_col   <= q_col;
      s2_flags <= s1_flags;
      s2_pixel <= s1_pixel;
      s2_col   <= s1_col;
      rd_data  <= lbuf[s1_col];
      fwd      <= s2_valid && (s2_col == s1_col);
      fwd_data <= wr_data;
    end
  end

  // Build the new window column with row replication at the frame edges.
  always_comb begin
    lb_word = fwd ? fwd_data : rd_data;
    new_col[1] = lb_word[PIXEL_W-1:0];
    new_col[0] = s2_flags.top_clamp ? lb_word[PIXEL_W-1:0] : lb_word[LB_W-1:PIXEL_W];
    new_col[2] = s2_flags.bot_clamp ? lb_word[PIXEL_W-1:0] : s2_pixel;
    wr_data    = {new_col[1], new_col[2]};
  end

  // Line buffer write and column shift.
  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      lbuf[s2_col] <= wr_data;
      col_a        <= new_col;
      col_b        <= col_a;
      col_c        <= col_b;
      s3_flags     <= s2_flags;
    end
  end

  // Column replication at the left and right edges.
  always_comb begin
    priority if (s3_flags.col_zero) begin
      win_l = s3_flags.w_one ? col_b : col_c;
      win_c = col_b;
      win_r = col_b;
    end else if (s3_flags.col_one) begin
      win_l = col_b;
      win_c = col_b;
      win_r = col_a;
    end else begin
      win_l = col_c;
      win_c = col_b;
      win_r = col_a;
    end
  end

  // Nine 8x8 products.
  always_comb begin
    krow[0] = k_top;
    krow[1] = k_mid;
    krow[2] = k_bot;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      prod_next[i][0] = PROD_W'(win_l[i]) * PROD_W'(krow[i][0 +: PIXEL_W]);
      prod_next[i][1] = PROD_W'(win_c[i]) * PROD_W'(krow[i][PIXEL_W +: PIXEL_W]);
      prod_next[i][2] = PROD_W'(win_r[i]) * PROD_W'(krow[i][2*PIXEL_W +: PIXEL_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= prod_next;
      s4_last <= s3_flags.last;
    end
  end

  // Row sums, then the total.
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      rsum_next[i] = ROWS_W'(prod[i][0]) + ROWS_W'(prod[i][1]) + ROWS_W'(prod[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsum    <= rsum_next;
      s5_last <= s4_last;
    end
  end

  assign total = VALUE_W'(rsum[0]) + VALUE_W'(rsum[1]) + VALUE_W'(rsum[2]);

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= total;
      out_last  <= s5_last;
    end
  end

endmodule

>>> hw/rtl/imconv_checker.sv
// ----------------------------------------------------------------------------
// imconv_checker
// Port-level checks of the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
module imconv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // The padding bits above the window sum stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:20] == 4'd0)
    else $error("output padding bits set");

  // A window sum of nine 8x8 products never exceeds its bound.
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[19:0] <= 20'd585225)
    else $error("window sum out of range");

  // Reset empties the datapath and the queue.
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

bind image_convolution_replicate_edges imconv_checker u_imconv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
